// ===== hw/rtl/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// concurrent assertion shorthands, clocked on i_clk, held off during reset
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TBPM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tbpm assertion failed");

// antecedent implies consequent in the next cycle
`define TBPM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tbpm assertion failed");

`endif

// ===== hw/rtl/tbpm_pkg.sv =====
// ============================================================================
// tbpm_pkg
// shared types and constants of the tilt bubble position mapper
// ============================================================================
`default_nettype none

package tbpm_pkg;

    // default module parameters
    localparam int MAX_PANEL_DEF     = 64;
    localparam int POS_FRAC_BITS_DEF = 8;

    // configuration register indexes
    localparam logic [2:0] REG_PANEL_W  = 3'd0;
    localparam logic [2:0] REG_PANEL_H  = 3'd1;
    localparam logic [2:0] REG_FS_SINE  = 3'd2;
    localparam logic [2:0] REG_ENG_SINE = 3'd3;
    localparam logic [2:0] REG_REL_SINE = 3'd4;
    localparam logic [2:0] REG_CR_SINE  = 3'd5;
    localparam logic [2:0] REG_BRIGHT   = 3'd6;

    // configuration reset values
    localparam logic [6:0]  RST_PANEL_W  = 7'd8;
    localparam logic [6:0]  RST_PANEL_H  = 7'd8;
    localparam logic [14:0] RST_FS_SINE  = 15'd11207;
    localparam logic [14:0] RST_ENG_SINE = 15'd286;
    localparam logic [14:0] RST_REL_SINE = 15'd572;
    localparam logic [14:0] RST_CR_SINE  = 15'd572;
    localparam logic [7:0]  RST_BRIGHT   = 8'd32;

    // iterative unit geometry
    localparam int NUM_W      = 64;
    localparam int DEN_W      = 32;
    localparam int RES_W      = 49;
    localparam int DIV_STEPS  = 49;
    localparam int SQRT_STEPS = 32;

    // iterative unit operations
    localparam logic MODE_DIV  = 1'b0;
    localparam logic MODE_SQRT = 1'b1;

    typedef struct packed {
        logic start;
        logic mode;
    } t_iter_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_rsp;

endpackage

`default_nettype wire

// ===== hw/rtl/tbpm_iter_unit.sv =====
// ============================================================================
// tbpm_iter_unit
// shared bit-serial unit: restoring divide (one quotient bit a cycle) and
// integer square root (one root bit a cycle) on one compare-subtract path
// ============================================================================
`default_nettype none

module tbpm_iter_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  tbpm_pkg::t_iter_req            i_req,
    input  wire [tbpm_pkg::NUM_W-1:0]      i_num,   // dividend (low bits) or radicand
    input  wire [tbpm_pkg::DEN_W-1:0]      i_den,
    output tbpm_pkg::t_iter_rsp            o_rsp,
    output logic [tbpm_pkg::RES_W-1:0]     o_result
);
    import tbpm_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic             r_mode;
    logic [5:0]       r_cnt;
    logic [NUM_W-1:0] r_acc;
    logic [33:0]      r_rem;
    logic [RES_W-1:0] r_res;
    logic [DEN_W-1:0] r_den;

    logic [33:0] cand;
    logic [33:0] opb;
    logic [34:0] diff;
    logic        ge;

    // shared compare and subtract
    always_comb begin
        if (r_mode == MODE_SQRT) begin
            cand = {r_rem[31:0], r_acc[NUM_W-1 -: 2]};
            opb  = {r_res[31:0], 2'b01};
        end else begin
            cand = {r_rem[32:0], r_acc[NUM_W-1]};
            opb  = {2'b00, r_den};
        end
        diff = {1'b0, cand} - {1'b0, opb};
        ge   = ~diff[34];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_mode <= i_req.mode;
            r_rem  <= '0;
            r_res  <= '0;
            r_den  <= i_den;
            if (i_req.mode == MODE_SQRT) begin
                r_acc <= i_num;
                r_cnt <= 6'(SQRT_STEPS - 1);
            end else begin
                r_acc <= {i_num[RES_W-1:0], {(NUM_W-RES_W){1'b0}}};
                r_cnt <= 6'(DIV_STEPS - 1);
            end
        end else if (r_busy) begin
            r_rem <= ge ? diff[33:0] : cand;
            r_res <= {r_res[RES_W-2:0], ge};
            r_cnt <= r_cnt - 6'd1;
            if (r_mode == MODE_SQRT) begin
                r_acc <= {r_acc[NUM_W-3:0], 2'b00};
            end else begin
                r_acc <= {r_acc[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_result   = r_res;

endmodule

`default_nettype wire

// ===== hw/rtl/tilt_bubble_position_mapper.sv =====
// ============================================================================
// tilt_bubble_position_mapper
// maps one tilt sample to a sub-pixel bubble position, level latch and colour
// ============================================================================
// Usage:
//  - s_axis carries one tilt sample per beat; m_axis returns one result beat
//    per sample. The config channel writes one register per beat and is
//    always ready; write only while no sample is in flight.
//  - Samples are worked one at a time by a small sequencer around a shared
//    bit-serial divide / square-root unit and a few small multipliers.
//    s_axis_tready is high only while the sequencer is idle.
//  - An invalid sample skips the shared unit. A valid sample runs a 49-step
//    divide for x, for y, and for proximity when the magnitude is below the
//    colour range; off scale adds a 32-step square root before the divides.
//  - The result sits in an output register; a new sample is accepted while
//    it waits, and the sequencer holds its next result until the receiver
//    takes the current one.
//  - Reset (synchronous, active low) loads the default registers, clears
//    the level latch and empties the output register.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module tilt_bubble_position_mapper #(
    parameter int MAX_PANEL     = tbpm_pkg::MAX_PANEL_DEF,
    parameter int POS_FRAC_BITS = tbpm_pkg::POS_FRAC_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config write channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [14:0] i_cfg_data,
    // sample input
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // tilt_x[15:0], tilt_y[31:16], tilt_magnitude[46:32]
    input  wire         s_axis_tuser,   // tilt_valid
    // result output
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // bubble_x[13:0], bubble_y[27:14], proximity[44:28],
                                        // color_red[52:45], color_green[60:53]
    output logic [1:0]  m_axis_tuser    // clamped[0], is_locked[1]
);
    import tbpm_pkg::*;

    localparam int DIM_W = $clog2(MAX_PANEL + 1);
    localparam int DW1   = (MAX_PANEL > 1) ? $clog2(MAX_PANEL) : 1;
    localparam int CW    = DW1 + POS_FRAC_BITS - 1;
    localparam int PW    = CW + 1;
    localparam int XW    = (PW > 14) ? PW : 14;
    localparam int MW    = 17 + CW;
    localparam int RW    = MW + 1 - 16;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // sequencer states
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_MULX  = 5'd1;
    localparam logic [4:0] ST_MULY  = 5'd2;
    localparam logic [4:0] ST_MULF  = 5'd3;
    localparam logic [4:0] ST_CHECK = 5'd4;
    localparam logic [4:0] ST_SQ_GO = 5'd5;
    localparam logic [4:0] ST_SQ_W  = 5'd6;
    localparam logic [4:0] ST_DX_GO = 5'd7;
    localparam logic [4:0] ST_DX_W  = 5'd8;
    localparam logic [4:0] ST_DY_GO = 5'd9;
    localparam logic [4:0] ST_DY_W  = 5'd10;
    localparam logic [4:0] ST_PROX  = 5'd11;
    localparam logic [4:0] ST_DP_GO = 5'd12;
    localparam logic [4:0] ST_DP_W  = 5'd13;
    localparam logic [4:0] ST_PMX   = 5'd14;
    localparam logic [4:0] ST_PMY   = 5'd15;
    localparam logic [4:0] ST_PAD   = 5'd16;
    localparam logic [4:0] ST_CMR   = 5'd17;
    localparam logic [4:0] ST_CMG   = 5'd18;
    localparam logic [4:0] ST_OUT   = 5'd19;

    // configuration registers
    logic [6:0]  r_pw, r_ph;
    logic [14:0] r_fs, r_eng, r_rel, r_cr;
    logic [7:0]  r_bright;
    logic        r_latch;

    // sample and working registers
    logic [4:0]  r_state, n_state;
    logic [15:0] r_ax, r_ay;
    logic        r_nx, r_ny, r_vld, r_off;
    logic [14:0] r_mag;
    logic [31:0] r_n;
    logic [29:0] r_fs2;
    logic [31:0] r_s;
    logic [16:0] r_tx, r_ty, r_prox;
    logic [MW-1:0] r_mx, r_my;
    logic [PW-1:0] r_posx, r_posy;
    logic [7:0]  r_red;
    logic [24:0] r_cprod;

    // output register
    logic        r_oval;
    logic [13:0] r_obx, r_oby;
    logic [16:0] r_oprox;
    logic [7:0]  r_ored, r_ogrn;
    logic        r_ooff, r_olock;

    // iterative unit interface
    t_iter_req          iter_req;
    t_iter_rsp          iter_rsp;
    logic [NUM_W-1:0]   iter_num;
    logic [DEN_W-1:0]   iter_den;
    logic [RES_W-1:0]   iter_res;
    logic [16:0]        q_clamp;

    logic [14:0] fs_eff, cr_eff;
    logic [DIM_W-1:0] dim_x, dim_y;
    logic [CW-1:0] cx, cy;
    logic [15:0] in_ax, in_ay;
    logic        in_acc, out_free, n_latch;

    // effective config values
    assign fs_eff = (r_fs == 15'd0) ? 15'd1 : r_fs;
    assign cr_eff = (r_cr == 15'd0) ? 15'd1 : r_cr;

    always_comb begin
        if (r_pw == 7'd0) begin
            dim_x = DIM_W'(1);
        end else if (int'(r_pw) > MAX_PANEL) begin
            dim_x = DIM_W'(MAX_PANEL);
        end else begin
            dim_x = DIM_W'(r_pw);
        end
        if (r_ph == 7'd0) begin
            dim_y = DIM_W'(1);
        end else if (int'(r_ph) > MAX_PANEL) begin
            dim_y = DIM_W'(MAX_PANEL);
        end else begin
            dim_y = DIM_W'(r_ph);
        end
    end

    // panel centre in position units
    assign cx = {DW1'(dim_x - DIM_W'(1)), {(POS_FRAC_BITS-1){1'b0}}};
    assign cy = {DW1'(dim_y - DIM_W'(1)), {(POS_FRAC_BITS-1){1'b0}}};

    // handshakes
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_oval || m_axis_tready;

    // sign and size of the input sines
    assign in_ax = s_axis_tdata[15] ? (16'd0 - s_axis_tdata[15:0])  : s_axis_tdata[15:0];
    assign in_ay = s_axis_tdata[31] ? (16'd0 - s_axis_tdata[31:16]) : s_axis_tdata[31:16];

    // level latch with hysteresis
    always_comb begin
        if (!s_axis_tuser || r_eng == 15'd0) begin
            n_latch = 1'b0;
        end else if (r_latch) begin
            n_latch = (s_axis_tdata[46:32] <= r_rel);
        end else begin
            n_latch = (s_axis_tdata[46:32] <= r_eng);
        end
    end

    // config writes and latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw     <= RST_PANEL_W;
            r_ph     <= RST_PANEL_H;
            r_fs     <= RST_FS_SINE;
            r_eng    <= RST_ENG_SINE;
            r_rel    <= RST_REL_SINE;
            r_cr     <= RST_CR_SINE;
            r_bright <= RST_BRIGHT;
            r_latch  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    REG_PANEL_W:  r_pw     <= i_cfg_data[6:0];
                    REG_PANEL_H:  r_ph     <= i_cfg_data[6:0];
                    REG_FS_SINE:  r_fs     <= i_cfg_data;
                    REG_ENG_SINE: r_eng    <= i_cfg_data;
                    REG_REL_SINE: r_rel    <= i_cfg_data;
                    REG_CR_SINE:  r_cr     <= i_cfg_data;
                    REG_BRIGHT:   r_bright <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_latch <= n_latch;
            end
        end
    end

    // operand select for the shared unit
    always_comb begin
        iter_req.start = 1'b0;
        iter_req.mode  = MODE_DIV;
        iter_num       = '0;
        iter_den       = '0;
        case (r_state)
            ST_SQ_GO: begin
                iter_req.start = 1'b1;
                iter_req.mode  = MODE_SQRT;
                iter_num       = {r_n, 32'd0};
            end
            ST_DX_GO, ST_DY_GO: begin
                iter_req.start = 1'b1;
                if (r_off) begin
                    iter_num = {16'd0, ((r_state == ST_DX_GO) ? r_ax : r_ay), 32'd0}
                             + {33'd0, r_s[31:1]};
                    iter_den = r_s;
                end else begin
                    iter_num = {32'd0, ((r_state == ST_DX_GO) ? r_ax : r_ay), 16'd0}
                             + {50'd0, fs_eff[14:1]};
                    iter_den = {17'd0, fs_eff};
                end
            end
            ST_DP_GO: begin
                iter_req.start = 1'b1;
                iter_num       = {33'd0, r_mag, 16'd0} + {50'd0, cr_eff[14:1]};
                iter_den       = {17'd0, cr_eff};
            end
            default: ;
        endcase
    end

    tbpm_iter_unit u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (iter_req),
        .i_num    (iter_num),
        .i_den    (iter_den),
        .o_rsp    (iter_rsp),
        .o_result (iter_res)
    );

    assign q_clamp = (iter_res > RES_W'(ONE_Q16)) ? ONE_Q16 : iter_res[16:0];

    // round travel times centre, clamp, and place about the centre
    function automatic logic [PW-1:0] axis_pos(input logic [MW-1:0] prod,
                                               input logic [CW-1:0] c,
                                               input logic neg);
        logic [RW-1:0] m;
        logic [CW-1:0] mc;
        begin
            m  = RW'(({1'b0, prod} + (MW+1)'(32768)) >> 16);
            mc = (m > RW'(c)) ? c : m[CW-1:0];
            axis_pos = neg ? ({1'b0, c} - {1'b0, mc}) : ({1'b0, c} + {1'b0, mc});
        end
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_acc) n_state = ST_MULX;
            ST_MULX:  n_state = ST_MULY;
            ST_MULY:  n_state = ST_MULF;
            ST_MULF:  n_state = ST_CHECK;
            ST_CHECK: begin
                if (!r_vld) begin
                    n_state = ST_PROX;
                end else if ({2'b00, r_fs2} < r_n) begin
                    n_state = ST_SQ_GO;
                end else begin
                    n_state = ST_DX_GO;
                end
            end
            ST_SQ_GO: n_state = ST_SQ_W;
            ST_SQ_W:  if (iter_rsp.done) n_state = ST_DX_GO;
            ST_DX_GO: n_state = ST_DX_W;
            ST_DX_W:  if (iter_rsp.done) n_state = ST_DY_GO;
            ST_DY_GO: n_state = ST_DY_W;
            ST_DY_W:  if (iter_rsp.done) n_state = ST_PROX;
            ST_PROX:  n_state = (r_vld && r_mag < cr_eff) ? ST_DP_GO : ST_PMX;
            ST_DP_GO: n_state = ST_DP_W;
            ST_DP_W:  if (iter_rsp.done) n_state = ST_PMX;
            ST_PMX:   n_state = ST_PMY;
            ST_PMY:   n_state = ST_PAD;
            ST_PAD:   n_state = ST_CMR;
            ST_CMR:   n_state = ST_CMG;
            ST_CMG:   n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && out_free) begin
                r_oval <= 1'b1;
            end else if (m_axis_tready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ax  <= in_ax;
                r_ay  <= in_ay;
                r_nx  <= s_axis_tdata[15];
                r_ny  <= s_axis_tdata[31];
                r_mag <= s_axis_tdata[46:32];
                r_vld <= s_axis_tuser;
                r_tx  <= '0;
                r_ty  <= '0;
            end
            ST_MULX:  r_n   <= r_ax * r_ax;
            ST_MULY:  r_n   <= r_n + r_ay * r_ay;
            ST_MULF:  r_fs2 <= fs_eff * fs_eff;
            ST_CHECK: r_off <= r_vld && ({2'b00, r_fs2} < r_n);
            ST_SQ_W:  if (iter_rsp.done) r_s <= iter_res[31:0];
            ST_DX_W:  if (iter_rsp.done) r_tx <= q_clamp;
            ST_DY_W:  if (iter_rsp.done) r_ty <= q_clamp;
            ST_PROX:  r_prox <= r_latch ? ONE_Q16 : 17'd0;
            ST_DP_W:  if (iter_rsp.done) r_prox <= r_latch ? ONE_Q16 : (ONE_Q16 - q_clamp);
            ST_PMX:   r_mx <= r_tx * cx;
            ST_PMY: begin
                r_my   <= r_ty * cy;
                r_posx <= axis_pos(r_mx, cx, r_nx);
            end
            ST_PAD:   r_posy  <= axis_pos(r_my, cy, r_ny);
            ST_CMR:   r_cprod <= r_bright * (ONE_Q16 - r_prox);
            ST_CMG: begin
                r_red   <= 8'(({1'b0, r_cprod} + 26'd32768) >> 16);
                r_cprod <= r_bright * r_prox;
            end
            ST_OUT: begin
                if (out_free) begin
                    r_obx   <= 14'(XW'(r_posx));
                    r_oby   <= 14'(XW'(r_posy));
                    r_oprox <= r_prox;
                    r_ored  <= r_red;
                    r_ogrn  <= 8'(({1'b0, r_cprod} + 26'd32768) >> 16);
                    r_ooff  <= r_off;
                    r_olock <= r_latch;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {3'd0, r_ogrn, r_ored, r_oprox, r_oby, r_obx};
    assign m_axis_tuser  = {r_olock, r_ooff};

    // checks
    `TBPM_ASSERT_NXT(a_one_sample_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `TBPM_ASSERT_IMP(a_locked_is_level, m_axis_tvalid && m_axis_tuser[1],
                     m_axis_tdata[44:28] == ONE_Q16)
    `TBPM_ASSERT_IMP(a_prox_in_range, m_axis_tvalid, m_axis_tdata[44:28] <= ONE_Q16)
    `TBPM_ASSERT_IMP(a_unit_started_idle, iter_req.start, !iter_rsp.busy)

endmodule

`default_nettype wire
